// ===== hdl/wmfc_pkg.sv =====
// Shared types and constants for the management frame classifier.
// Used by wmfc_parser, wmfc_emitter and wlan_mgmt_frame_classifier.
`timescale 1ns / 1ps
package wmfc_pkg;

   // Frame and SSID limits
   localparam int MAX_SSID_BYTES  = 32;
   localparam int MAX_FRAME_BYTES = 4095;
   localparam int COUNT_W         = $clog2(MAX_FRAME_BYTES + 1);
   localparam int SSID_IDX_W      = (MAX_SSID_BYTES > 1) ? $clog2(MAX_SSID_BYTES) : 1;
   localparam int SSID_LEN_W      = 6;

   // Frame layout
   localparam int MIN_FRAME_BYTES = 24;
   localparam int BEACON_SSID_OFS = 36;
   localparam int PROBE_SSID_OFS  = 24;
   localparam int BEACON_ADDR_OFS = 16;
   localparam int PROBE_ADDR_OFS  = 10;
   localparam int ADDR_BYTES      = 6;

   // Frame control, low octet
   localparam logic [7:0] FC_TYPE_MASK    = 8'h0C;
   localparam logic [7:0] FC_SUBTYPE_MASK = 8'hF0;
   localparam logic [1:0] FC_TYPE_MGMT    = 2'd0;

   localparam logic [3:0] SUBTYPE_DEAUTH    = 4'hC;
   localparam logic [3:0] SUBTYPE_DISASSOC  = 4'hA;
   localparam logic [3:0] SUBTYPE_BEACON    = 4'h8;
   localparam logic [3:0] SUBTYPE_PROBE_REQ = 4'h4;

   // Printable range and replacement character
   localparam logic [7:0] PRINT_LOW  = 8'd32;
   localparam logic [7:0] PRINT_HIGH = 8'd127;
   localparam logic [7:0] SUBST_CHAR = 8'h2E;

   typedef enum logic [1:0] {
      KIND_BEACON    = 2'd0,
      KIND_PROBE_REQ = 2'd1,
      KIND_DEAUTH    = 2'd2
   } frame_kind_type;

   // Fields held for the frame being reported
   typedef struct packed {
      frame_kind_type      kind;
      logic [47:0]         address;
      logic signed [7:0]   strength;
      logic [3:0]          channel;
   } frame_info_type;

   // Request from the parser to start a result run
   typedef struct packed {
      logic                  start;
      logic [SSID_LEN_W-1:0] len;
   } run_req_type;

endpackage

// ===== hdl/wlan_mgmt_frame_classifier.sv =====
// Run start: the accepted last byte of a reported frame sets busy, and the result register then loads its first result.
// Throughput: one byte per cycle while no run is being sent; after a reported frame,
// req_tready stays low until all of its results (1 to 32) are loaded, and rsp_tready can hold them back.
// Reset: synchronous, active high; clears frame state, run state and rsp_tvalid; the SSID
// store is not cleared, since only characters written in the same frame are read.
// Top level of the frame classifier; depends on wmfc_pkg, wmfc_parser, wmfc_emitter.
`timescale 1ns / 1ps
module wlan_mgmt_frame_classifier
   import wmfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // data_byte[7:0], signal_strength[15:8],
                                    // radio_channel[19:16], zero[23:20]
   input  logic        req_tuser,   // frame_start
   input  logic        req_tlast,   // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // station_address[47:0], strength_out[55:48],
                                    // channel_out[59:56], ssid_length[65:60],
                                    // char_position[70:66], ssid_char[78:71], zero[79]
   output logic [1:0]  rsp_tuser,   // frame_kind
   output logic        rsp_tlast    // last_of_run
);

   logic                  byte_accept;
   logic                  busy;
   logic [SSID_IDX_W-1:0] rd_index;
   logic [7:0]            rd_char;
   frame_info_type        info;
   run_req_type           run_req;
   frame_kind_type        rsp_kind;
   logic [47:0]           rsp_address;
   logic signed [7:0]     rsp_strength;
   logic [3:0]            rsp_channel;
   logic [SSID_LEN_W-1:0] rsp_length;
   logic [4:0]            rsp_position;
   logic [7:0]            rsp_char;

   // Take a word whenever no run is being sent
   assign req_tready  = !busy;
   assign byte_accept = req_tvalid && req_tready;

   wmfc_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .byte_accept     (byte_accept),
      .data_byte       (req_tdata[7:0]),
      .frame_start     (req_tuser),
      .frame_end       (req_tlast),
      .signal_strength (req_tdata[15:8]),
      .radio_channel   (req_tdata[19:16]),
      .rd_index        (rd_index),
      .rd_char         (rd_char),
      .info            (info),
      .run_req         (run_req)
   );

   wmfc_emitter u_emitter (
      .clock        (clock),
      .reset        (reset),
      .run_req      (run_req),
      .info         (info),
      .rd_char      (rd_char),
      .rd_index     (rd_index),
      .busy         (busy),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_kind     (rsp_kind),
      .rsp_address  (rsp_address),
      .rsp_strength (rsp_strength),
      .rsp_channel  (rsp_channel),
      .rsp_length   (rsp_length),
      .rsp_position (rsp_position),
      .rsp_char     (rsp_char),
      .rsp_last     (rsp_tlast)
   );

   // Pack the result word
   assign rsp_tdata = {1'b0, rsp_char, rsp_position, rsp_length, rsp_channel,
                       rsp_strength, rsp_address};
   assign rsp_tuser = rsp_kind;

endmodule

// ===== hdl/wmfc_parser.sv =====
// Byte parser: frame position counter, header decode, address and SSID capture.
// Depends on wmfc_pkg.
`timescale 1ns / 1ps
module wmfc_parser
   import wmfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_accept,
   input  logic [7:0]            data_byte,
   input  logic                  frame_start,
   input  logic                  frame_end,
   input  logic signed [7:0]     signal_strength,
   input  logic [3:0]            radio_channel,
   input  logic [SSID_IDX_W-1:0] rd_index,
   output logic [7:0]            rd_char,
   output frame_info_type        info,
   output run_req_type           run_req
);

   localparam int POS_W = COUNT_W + 1;

   logic [COUNT_W-1:0]    byte_count_ff, byte_count_in;
   frame_kind_type        kind_ff, kind_in;
   logic                  keep_ff, keep_in;
   logic [47:0]           address_ff, address_in;
   logic                  tag_ok_ff, tag_ok_in;
   logic [7:0]            raw_len_ff, raw_len_in;
   logic signed [7:0]     strength_ff, strength_in;
   logic [3:0]            channel_ff, channel_in;
   logic [7:0]            store_ff [MAX_SSID_BYTES];

   logic [COUNT_W-1:0]    pos;
   logic [COUNT_W-1:0]    total;
   logic [POS_W-1:0]      pos_x;
   logic [POS_W-1:0]      total_x;
   logic [POS_W-1:0]      addr_ofs;
   logic [POS_W-1:0]      ssid_ofs;
   logic [POS_W-1:0]      store_ofs;
   logic [POS_W-1:0]      ssid_end_x;
   logic [1:0]            fc_type;
   logic [3:0]            fc_subtype;
   logic                  store_we;
   logic [SSID_IDX_W-1:0] store_waddr;
   logic [7:0]            store_wdata;
   logic [SSID_LEN_W-1:0] capped_len;
   logic [SSID_LEN_W-1:0] run_len;

   // Position of this byte in its frame
   always_comb begin
      pos       = frame_start ? '0 : byte_count_ff;
      total     = (pos != COUNT_W'(MAX_FRAME_BYTES)) ? pos + 1'b1 : pos;
      pos_x     = {1'b0, pos};
      total_x   = {1'b0, total};
      fc_type   = data_byte[3:2] & FC_TYPE_MASK[3:2];
      fc_subtype = data_byte[7:4] & FC_SUBTYPE_MASK[7:4];
      addr_ofs  = (kind_ff == KIND_BEACON) ? POS_W'(BEACON_ADDR_OFS)
                                           : POS_W'(PROBE_ADDR_OFS);
      ssid_ofs  = (kind_ff == KIND_BEACON) ? POS_W'(BEACON_SSID_OFS)
                                           : POS_W'(PROBE_SSID_OFS);
      store_ofs = pos_x - ssid_ofs - POS_W'(2);
   end

   // Update the frame state for an accepted byte
   always_comb begin
      byte_count_in = byte_count_ff;
      kind_in       = kind_ff;
      keep_in       = keep_ff;
      address_in    = address_ff;
      tag_ok_in     = tag_ok_ff;
      raw_len_in    = raw_len_ff;
      strength_in   = strength_ff;
      channel_in    = channel_ff;
      store_we      = 1'b0;
      store_waddr   = store_ofs[SSID_IDX_W-1:0];
      store_wdata   = ((data_byte >= PRINT_LOW) && (data_byte < PRINT_HIGH)) ?
                      data_byte : SUBST_CHAR;
      if (byte_accept) begin
         byte_count_in = frame_end ? '0 : total;
         if (pos == '0) begin
            // First byte: latch radio info, decode frame control
            strength_in = signal_strength;
            channel_in  = radio_channel;
            address_in  = '0;
            tag_ok_in   = 1'b0;
            raw_len_in  = '0;
            keep_in     = 1'b0;
            kind_in     = KIND_BEACON;
            if (fc_type == FC_TYPE_MGMT) begin
               if (fc_subtype == SUBTYPE_DEAUTH ||
                   fc_subtype == SUBTYPE_DISASSOC) begin
                  kind_in = KIND_DEAUTH;
                  keep_in = 1'b1;
               end else if (fc_subtype == SUBTYPE_BEACON) begin
                  kind_in = KIND_BEACON;
                  keep_in = 1'b1;
               end else if (fc_subtype == SUBTYPE_PROBE_REQ) begin
                  kind_in = KIND_PROBE_REQ;
                  keep_in = 1'b1;
               end
            end
         end else if (keep_ff && kind_ff != KIND_DEAUTH) begin
            // Shift in address octets
            if (pos_x >= addr_ofs && pos_x < addr_ofs + POS_W'(ADDR_BYTES)) begin
               address_in = {address_ff[39:0], data_byte};
            end
            // SSID element: tag, length, then characters
            if (pos_x == ssid_ofs) begin
               tag_ok_in = (data_byte == 8'd0);
            end else if (pos_x == ssid_ofs + POS_W'(1)) begin
               raw_len_in = data_byte;
            end else if (pos_x >= ssid_ofs + POS_W'(2) &&
                         pos_x < ssid_ofs + POS_W'(2 + MAX_SSID_BYTES)) begin
               store_we = 1'b1;
            end
         end
      end
   end

   // Decide the result run at the frame's last byte
   always_comb begin
      capped_len = (raw_len_ff > 8'(MAX_SSID_BYTES)) ? SSID_LEN_W'(MAX_SSID_BYTES)
                                                     : raw_len_ff[SSID_LEN_W-1:0];
      ssid_end_x = ssid_ofs + POS_W'(2) + POS_W'(capped_len);
      run_len    = '0;
      if (kind_ff != KIND_DEAUTH && tag_ok_ff &&
          ssid_ofs + POS_W'(2) <= total_x && ssid_end_x <= total_x) begin
         run_len = capped_len;
      end
      run_req.start = byte_accept && frame_end && keep_ff &&
                      (total >= COUNT_W'(MIN_FRAME_BYTES));
      run_req.len   = run_len;
   end

   // Hold frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         kind_ff       <= KIND_BEACON;
         keep_ff       <= 1'b0;
         address_ff    <= '0;
         tag_ok_ff     <= 1'b0;
         raw_len_ff    <= '0;
         strength_ff   <= '0;
         channel_ff    <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
         kind_ff       <= kind_in;
         keep_ff       <= keep_in;
         address_ff    <= address_in;
         tag_ok_ff     <= tag_ok_in;
         raw_len_ff    <= raw_len_in;
         strength_ff   <= strength_in;
         channel_ff    <= channel_in;
      end
   end

   // SSID character store
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[store_waddr] <= store_wdata;
      end
   end

   assign rd_char       = store_ff[rd_index];
   assign info.kind     = kind_ff;
   assign info.address  = address_ff;
   assign info.strength = strength_ff;
   assign info.channel  = channel_ff;

endmodule

// ===== hdl/wmfc_emitter.sv =====
// Result sequencer: walks the SSID store and fills the result register.
// Depends on wmfc_pkg.
`timescale 1ns / 1ps
module wmfc_emitter
   import wmfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  run_req_type           run_req,
   input  frame_info_type        info,
   input  logic [7:0]            rd_char,
   output logic [SSID_IDX_W-1:0] rd_index,
   output logic                  busy,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output frame_kind_type        rsp_kind,
   output logic [47:0]           rsp_address,
   output logic signed [7:0]     rsp_strength,
   output logic [3:0]            rsp_channel,
   output logic [SSID_LEN_W-1:0] rsp_length,
   output logic [4:0]            rsp_position,
   output logic [7:0]            rsp_char,
   output logic                  rsp_last
);

   logic                  busy_ff, busy_in;
   logic [SSID_IDX_W-1:0] idx_ff, idx_in;
   logic [SSID_LEN_W-1:0] len_ff, len_in;
   logic                  valid_ff, valid_in;
   logic                  load;
   logic                  at_last;

   frame_kind_type        kind_ff;
   logic [47:0]           address_ff;
   logic signed [7:0]     strength_ff;
   logic [3:0]            channel_ff;
   logic [SSID_LEN_W-1:0] length_ff;
   logic [4:0]            position_ff;
   logic [7:0]            char_ff;
   logic                  last_ff;

   // Advance through the run while the result register has room
   always_comb begin
      load    = busy_ff && (!valid_ff || rsp_ready);
      at_last = (len_ff == '0) ||
                (SSID_LEN_W'(idx_ff) + SSID_LEN_W'(1) == len_ff);
      busy_in = busy_ff;
      idx_in  = idx_ff;
      len_in  = len_ff;
      if (run_req.start) begin
         busy_in = 1'b1;
         idx_in  = '0;
         len_in  = run_req.len;
      end else if (load) begin
         if (at_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         idx_ff   <= '0;
         len_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         len_ff   <= len_in;
         valid_ff <= valid_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff     <= info.kind;
         address_ff  <= (info.kind == KIND_DEAUTH) ? '0 : info.address;
         strength_ff <= info.strength;
         channel_ff  <= info.channel;
         length_ff   <= len_ff;
         position_ff <= 5'(idx_ff);
         char_ff     <= (len_ff == '0) ? 8'd0 : rd_char;
         last_ff     <= at_last;
      end
   end

   assign rd_index     = idx_ff;
   assign busy         = busy_ff;
   assign rsp_valid    = valid_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_address  = address_ff;
   assign rsp_strength = strength_ff;
   assign rsp_channel  = channel_ff;
   assign rsp_length   = length_ff;
   assign rsp_position = position_ff;
   assign rsp_char     = char_ff;
   assign rsp_last     = last_ff;

endmodule
